@@ design/pef_pkg.sv @@
// Shared types and constants for the priority extract queue.
package pef_pkg;

  localparam int QUEUE_DEPTH   = 16;
  localparam int PAYLOAD_BITS  = 32;
  localparam int PRIORITY_BITS = 8;
  localparam int ADDR_BITS     = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS      = $clog2(QUEUE_DEPTH + 1);

  // Request codes
  localparam logic [1:0] REQ_ENQ  = 2'd0;
  localparam logic [1:0] REQ_DEQ  = 2'd1;
  localparam logic [1:0] REQ_PRI  = 2'd2;

  // Status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]               req_type;
    logic [PAYLOAD_BITS-1:0]  in_payload;
    logic [PRIORITY_BITS-1:0] in_priority;
  } req_t;

  typedef struct packed {
    logic [PAYLOAD_BITS-1:0]  out_payload;
    logic [PRIORITY_BITS-1:0] out_priority;
    logic [1:0]               status;
    logic [CNT_BITS-1:0]      occupancy_now;
  } rsp_t;

  typedef struct packed {
    logic [PAYLOAD_BITS-1:0]  payload;
    logic [PRIORITY_BITS-1:0] pri;
  } entry_t;

  typedef struct packed {
    logic                 we;
    logic [ADDR_BITS-1:0] waddr;
    entry_t               wdata;
    logic                 re;
    logic [ADDR_BITS-1:0] raddr;
  } mem_req_t;

endpackage

@@ design/pef_store.sv @@
// Entry storage: one write port, one registered read port.
module pef_store (
  input  logic              clk,
  input  pef_pkg::mem_req_t mem,
  output pef_pkg::entry_t   rd_data
);
  import pef_pkg::*;

  entry_t slots [QUEUE_DEPTH];

  // Write one entry
  always_ff @(posedge clk) begin
    if (mem.we) begin
      slots[mem.waddr] <= mem.wdata;
    end
  end

  // Read one entry, data in the next cycle
  always_ff @(posedge clk) begin
    if (mem.re) begin
      rd_data <= slots[mem.raddr];
    end
  end

endmodule

@@ design/pef_ctrl.sv @@
// Sequencer: scans entries through the shared compare, then compacts the queue.
module pef_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  pef_pkg::req_t     req,
  output pef_pkg::mem_req_t mem,
  input  pef_pkg::entry_t   rd_data,
  output logic              done_valid,
  input  logic              take,
  output pef_pkg::rsp_t     done
);
  import pef_pkg::*;

  state_t               state;
  state_t               state_next;
  logic [CNT_BITS-1:0]  occ;
  logic [CNT_BITS-1:0]  idx;
  logic [CNT_BITS-1:0]  lim;
  logic                 rd_pend;
  logic [ADDR_BITS-1:0] rd_idx;
  logic [ADDR_BITS-1:0] best_idx;
  entry_t               best;
  logic [PAYLOAD_BITS-1:0]  res_pay;
  logic [PRIORITY_BITS-1:0] res_pri;
  logic [1:0]           res_status;

  logic accept;
  logic full;
  logic scan_end;
  logic shift_end;
  logic take_best;

  assign accept    = req_valid && req_ready;
  assign full      = (occ == CNT_BITS'(QUEUE_DEPTH));
  assign scan_end  = (idx == lim) && !rd_pend;
  assign shift_end = (idx >= occ) && !rd_pend;
  assign take_best = rd_pend && ((rd_idx == '0) || (rd_data.pri > best.pri));

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if ((req.req_type == REQ_DEQ || req.req_type == REQ_PRI) && occ != '0) begin
            state_next = S_SCAN;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          state_next = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (shift_end) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (take) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs and memory port
  always_comb begin
    req_ready  = (state == S_IDLE);
    done_valid = (state == S_DONE);
    mem.re     = ((state == S_SCAN) && (idx < lim)) || ((state == S_SHIFT) && (idx < occ));
    mem.raddr  = idx[ADDR_BITS-1:0];
    if (state == S_SHIFT) begin
      mem.we    = rd_pend;
      mem.waddr = rd_idx - ADDR_BITS'(1);
      mem.wdata = rd_data;
    end else begin
      mem.we    = accept && (req.req_type == REQ_ENQ) && !full;
      mem.waddr = occ[ADDR_BITS-1:0];
      mem.wdata = '{payload: req.in_payload, pri: req.in_priority};
    end
    done.out_payload   = res_pay;
    done.out_priority  = res_pri;
    done.status        = res_status;
    done.occupancy_now = occ;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      occ     <= '0;
      rd_pend <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= mem.re;
      if (state == S_IDLE && accept && req.req_type == REQ_ENQ && !full) begin
        occ <= occ + CNT_BITS'(1);
      end else if (state == S_SHIFT && shift_end) begin
        occ <= occ - CNT_BITS'(1);
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    rd_idx <= mem.raddr;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          res_pay    <= '0;
          res_pri    <= '0;
          idx        <= '0;
          lim        <= (req.req_type == REQ_PRI) ? occ : CNT_BITS'(1);
          if (req.req_type == REQ_ENQ && full) begin
            res_status <= STAT_FULL;
          end else if ((req.req_type == REQ_DEQ || req.req_type == REQ_PRI) && occ == '0) begin
            res_status <= STAT_EMPTY;
          end else begin
            res_status <= STAT_OK;
          end
        end
      end
      S_SCAN: begin
        // Advance read pointer, keep the earliest highest priority
        if (idx < lim) begin
          idx <= idx + CNT_BITS'(1);
        end
        if (take_best) begin
          best     <= rd_data;
          best_idx <= rd_idx;
        end
        if (scan_end) begin
          idx <= CNT_BITS'(best_idx) + CNT_BITS'(1);
        end
      end
      S_SHIFT: begin
        // Move each later entry down one slot
        if (idx < occ) begin
          idx <= idx + CNT_BITS'(1);
        end
        if (shift_end) begin
          res_pay <= best.payload;
          res_pri <= best.pri;
        end
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= CNT_BITS'(QUEUE_DEPTH))
    else $error("occupancy above depth");

  a_shift_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT && mem.we) |-> (CNT_BITS'(mem.waddr) + CNT_BITS'(1) < occ))
    else $error("compaction write outside held entries");

  a_enq_grow: assert property (@(posedge clk) disable iff (rst)
    (accept && req.req_type == REQ_ENQ && !full) |=> (occ == $past(occ) + CNT_BITS'(1)))
    else $error("enqueue did not grow occupancy");

  a_scan_limit: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (lim <= occ && lim != '0))
    else $error("scan limit outside held entries");
`endif

endmodule

@@ design/priority_extract_fifo_top.sv @@
// Top level of the priority extract queue: sequencer, storage and result register.
//
// Request channel (req_valid/req_ready/req): one beat per request, req_type
// selects enqueue, dequeue of the head, or dequeue of the highest priority
// entry (earliest arrival on a tie). Response channel (rsp_valid/rsp_ready/rsp)
// returns exactly one beat per request with the removed entry, a status and
// the occupancy after the request.
// Enqueue, a rejected request or an unused code goes to the response without
// a scan. A dequeue with N entries held runs the shared compare over the
// scanned entries one per cycle (one entry for head dequeue, N for priority
// dequeue), then compacts the entries behind the removed one through the
// single storage read port, one per cycle.
// One request is in flight at a time; req_ready is high only between requests.
// Reset empties the queue at once; entry storage is not cleared.
// When the receiver stalls, the finished response waits in the result
// register and the next request is still taken; its response waits inside
// until the register frees.
module priority_extract_fifo_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  pef_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output pef_pkg::rsp_t rsp
);
  import pef_pkg::*;

  mem_req_t mem;
  entry_t   rd_data;
  logic     done_valid;
  rsp_t     done;
  logic     take;

  assign take = !rsp_valid || rsp_ready;

  pef_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .mem        (mem),
    .rd_data    (rd_data),
    .done_valid (done_valid),
    .take       (take),
    .done       (done)
  );

  pef_store u_store (
    .clk     (clk),
    .mem     (mem),
    .rd_data (rd_data)
  );

  // Hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (done_valid && take) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_valid && take) begin
      rsp <= done;
    end
  end

endmodule
